// ===== design/qrs_pkg.sv =====
// shared types and constants for the quadratic root solver
package qrs_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned ROOT_W        = 33;  // bits of floor(sqrt(|D|))

  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_LINEAR  = 3'd1,
    KIND_DOUBLE  = 3'd2,
    KIND_REAL    = 3'd3,
    KIND_COMPLEX = 3'd4
  } kind_e;

  // magnitude of a two's complement word, 2^31 fits unsigned
  function automatic logic [COEF_W-1:0] mag32(input logic [COEF_W-1:0] v);
    return v[COEF_W-1] ? (~v + COEF_W'(1)) : v;
  endfunction

endpackage

// ===== design/qrs_sqrt_cell.sv =====
// one restoring square root cell, two radicand bits and one root bit per cell
module qrs_sqrt_cell import qrs_pkg::*; #(
  parameter int unsigned RW = ROOT_W,
  parameter int unsigned SW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [2*RW-1:0]   rad_o,
  output logic [RW+1:0]     rem_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     side_o
);

  localparam int unsigned RADW = 2 * RW;
  localparam int unsigned REMW = RW + 2;

  logic              valid_q;
  logic [RADW-1:0]   rad_q, rad_d;
  logic [REMW-1:0]   rem_q, rem_d;
  logic [RW-1:0]     root_q, root_d;
  logic [SW-1:0]     side_q;
  logic [REMW+1:0]   trial, sub, diff;
  logic              ge;

  always_comb begin
    trial  = {rem_i, rad_i[RADW-1:RADW-2]};
    sub    = {2'b00, root_i, 2'b01};
    diff   = trial - sub;
    ge     = trial >= sub;
    rem_d  = ge ? diff[REMW-1:0] : trial[REMW-1:0];
    root_d = {root_i[RW-2:0], ge};
    rad_d  = {rad_i[RADW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ===== design/qrs_div_cell.sv =====
// one restoring divider cell, one quotient bit per cell
module qrs_div_cell import qrs_pkg::*; #(
  parameter int unsigned NW = FRAC_BITS_DEF + 34,
  parameter int unsigned SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     num_i,
  input  logic [COEF_W-1:0] rem_i,
  input  logic [NW-1:0]     quo_i,
  input  logic [COEF_W-1:0] den_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [NW-1:0]     num_o,
  output logic [COEF_W-1:0] rem_o,
  output logic [NW-1:0]     quo_o,
  output logic [COEF_W-1:0] den_o,
  output logic [SW-1:0]     side_o
);

  logic              valid_q;
  logic [NW-1:0]     num_q, quo_q, quo_d;
  logic [COEF_W-1:0] rem_q, rem_d, den_q;
  logic [SW-1:0]     side_q;
  logic [COEF_W:0]   trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
    quo_d = {quo_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= {num_i[NW-2:0], 1'b0};
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

// ===== design/quadratic_root_solver.sv =====
// quadratic root solver top level: front end, square root row, divider rows, output word
//
// takes one coefficient word (a, b, c of a*x^2 + b*x + c = 0, signed fixed point with
// FRAC_BITS fraction bits) per clock and returns one result word per clock: a kind code
// (invalid, linear root, double root, two real roots, complex pair), two fixed point
// values and a saturation flag. the whole datapath is one pipeline of 38 + FRAC_BITS + 34
// register stages: input register, two 32x32 multipliers, exact discriminant, a row of
// 33 square root cells (one root bit each), numerator setup, two parallel rows of
// FRAC_BITS + 34 divider cells (one quotient bit each), and the output register. all
// stages advance together whenever the output register is empty or
// being read, so a new word enters every cycle as long as results are taken. zero_threshold
// is written through the cfg channel, which is always ready; write it only while idle
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // coefficient channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [COEF_W-1:0] coef_a_i,
  input  logic [COEF_W-1:0] coef_b_i,
  input  logic [COEF_W-1:0] coef_c_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        kind_o,
  output logic [COEF_W-1:0] first_value_o,
  output logic [COEF_W-1:0] second_value_o,
  output logic              saturated_o,
  // threshold write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [COEF_W-1:0] cfg_data_i
);

  localparam int unsigned NW   = FRAC_BITS + 34;   // numerator and quotient width
  localparam int unsigned RW   = ROOT_W;
  localparam int unsigned RADW = 2 * RW;           // discriminant magnitude width
  localparam int unsigned SQSW = 3 + 3 * COEF_W;   // kind, a, b, c along the root row
  localparam int unsigned DASW = 4;                // kind, sign of first value
  localparam int unsigned DBSW = 1;                // sign of second value

  // global advance: the output register is free or being taken
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // threshold register
  logic [COEF_W-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // stage 1: input word
  logic              s1_v_q;
  logic [COEF_W-1:0] s1_a_q, s1_b_q, s1_c_q;

  // stage 2: products
  logic              s2_v_q;
  logic [COEF_W-1:0] s2_a_q, s2_b_q, s2_c_q;
  logic [63:0]       s2_b2_q, s2_p_q;

  // stage 3: discriminant magnitude and kind
  logic              s3_v_q;
  logic [COEF_W-1:0] s3_a_q, s3_b_q, s3_c_q;
  logic [RADW-1:0]   s3_dmag_q, dmag_d;
  kind_e             s3_kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // exact D = b^2 - 4ac; a negative ac product adds
  logic [RADW-1:0] b2x, p4;
  logic            acneg, dneg;
  always_comb begin
    b2x   = RADW'(s2_b2_q);
    p4    = RADW'({s2_p_q, 2'b00});
    acneg = (s2_a_q[COEF_W-1] ^ s2_c_q[COEF_W-1]) && (s2_c_q != '0);
    dneg  = !acneg && (p4 > b2x);
    if (acneg) begin
      dmag_d = b2x + p4;
    end else if (dneg) begin
      dmag_d = p4 - b2x;
    end else begin
      dmag_d = b2x - p4;
    end
    if (s2_a_q == '0) begin
      kind_d = (s2_b_q != '0) ? KIND_LINEAR : KIND_INVALID;
    end else if (dmag_d <= RADW'(thr_q)) begin
      kind_d = KIND_DOUBLE;
    end else if (dneg) begin
      kind_d = KIND_COMPLEX;
    end else begin
      kind_d = KIND_REAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q    <= coef_a_i;
      s1_b_q    <= coef_b_i;
      s1_c_q    <= coef_c_i;
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_c_q    <= s1_c_q;
      s2_b2_q   <= mag32(s1_b_q) * mag32(s1_b_q);
      s2_p_q    <= mag32(s1_a_q) * mag32(s1_c_q);
      s3_a_q    <= s2_a_q;
      s3_b_q    <= s2_b_q;
      s3_c_q    <= s2_c_q;
      s3_dmag_q <= dmag_d;
      s3_kind_q <= kind_d;
    end
  end

  // square root row
  logic              sq_v    [RW+1];
  logic [RADW-1:0]   sq_rad  [RW+1];
  logic [RW+1:0]     sq_rem  [RW+1];
  logic [RW-1:0]     sq_root [RW+1];
  logic [SQSW-1:0]   sq_side [RW+1];

  assign sq_v[0]    = s3_v_q;
  assign sq_rad[0]  = s3_dmag_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {s3_kind_q, s3_a_q, s3_b_q, s3_c_q};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.RW(RW), .SW(SQSW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_v[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // numerator setup from s and the coefficients
  kind_e             r_kind;
  logic [COEF_W-1:0] r_a, r_b, r_c;
  logic [RW+1:0]     s35, b35, n1, n2, n1m, n2m;
  logic [NW-1:0]     num1_d, num2_d;
  logic [COEF_W-1:0] den_d;
  logic              neg1_d, neg2_d, bpos;

  always_comb begin
    r_kind = kind_e'(sq_side[RW][SQSW-1 -: 3]);
    r_a    = sq_side[RW][3*COEF_W-1 -: COEF_W];
    r_b    = sq_side[RW][2*COEF_W-1 -: COEF_W];
    r_c    = sq_side[RW][COEF_W-1:0];
    s35    = {2'b00, sq_root[RW]};
    b35    = {{(RW+2-COEF_W){r_b[COEF_W-1]}}, r_b};
    n1     = s35 - b35;
    n2     = -b35 - s35;
    n1m    = n1[RW+1] ? -n1 : n1;
    n2m    = n2[RW+1] ? -n2 : n2;
    bpos   = !r_b[COEF_W-1] && (r_b != '0);
    den_d  = (r_kind == KIND_LINEAR) ? mag32(r_b) : mag32(r_a);
    num1_d = '0;
    num2_d = '0;
    neg1_d = 1'b0;
    neg2_d = 1'b0;
    unique case (r_kind)
      KIND_LINEAR: begin
        num1_d = NW'(mag32(r_c)) << FRAC_BITS;
        neg1_d = (!r_c[COEF_W-1] && (r_c != '0)) ^ r_b[COEF_W-1];
      end
      KIND_DOUBLE: begin
        num1_d = NW'(mag32(r_b)) << (FRAC_BITS - 1);
        neg1_d = bpos ^ r_a[COEF_W-1];
      end
      KIND_REAL: begin
        num1_d = NW'(n1m) << (FRAC_BITS - 1);
        neg1_d = n1[RW+1] ^ r_a[COEF_W-1];
        num2_d = NW'(n2m) << (FRAC_BITS - 1);
        neg2_d = n2[RW+1] ^ r_a[COEF_W-1];
      end
      KIND_COMPLEX: begin
        num1_d = NW'(mag32(r_b)) << (FRAC_BITS - 1);
        neg1_d = bpos ^ r_a[COEF_W-1];
        num2_d = NW'(sq_root[RW]) << (FRAC_BITS - 1);
        neg2_d = r_a[COEF_W-1];
      end
      default: begin
        num1_d = '0;
      end
    endcase
  end

  logic              s4_v_q;
  logic [NW-1:0]     s4_num1_q, s4_num2_q;
  logic [COEF_W-1:0] s4_den_q;
  logic              s4_neg1_q, s4_neg2_q;
  kind_e             s4_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= sq_v[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_num1_q <= num1_d;
      s4_num2_q <= num2_d;
      s4_den_q  <= den_d;
      s4_neg1_q <= neg1_d;
      s4_neg2_q <= neg2_d;
      s4_kind_q <= r_kind;
    end
  end

  // divider rows, lane a carries the word's valid and kind
  logic              da_v    [NW+1];
  logic [NW-1:0]     da_num  [NW+1];
  logic [COEF_W-1:0] da_rem  [NW+1];
  logic [NW-1:0]     da_quo  [NW+1];
  logic [COEF_W-1:0] da_den  [NW+1];
  logic [DASW-1:0]   da_side [NW+1];
  logic              db_v    [NW+1];
  logic [NW-1:0]     db_num  [NW+1];
  logic [COEF_W-1:0] db_rem  [NW+1];
  logic [NW-1:0]     db_quo  [NW+1];
  logic [COEF_W-1:0] db_den  [NW+1];
  logic [DBSW-1:0]   db_side [NW+1];

  assign da_v[0]    = s4_v_q;
  assign da_num[0]  = s4_num1_q;
  assign da_rem[0]  = '0;
  assign da_quo[0]  = '0;
  assign da_den[0]  = s4_den_q;
  assign da_side[0] = {s4_kind_q, s4_neg1_q};
  assign db_v[0]    = s4_v_q;
  assign db_num[0]  = s4_num2_q;
  assign db_rem[0]  = '0;
  assign db_quo[0]  = '0;
  assign db_den[0]  = s4_den_q;
  assign db_side[0] = s4_neg2_q;

  for (genvar i = 0; i < NW; i++) begin : g_div
    qrs_div_cell #(.NW(NW), .SW(DASW)) u_cell_a (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (da_v[i]),
      .num_i   (da_num[i]),
      .rem_i   (da_rem[i]),
      .quo_i   (da_quo[i]),
      .den_i   (da_den[i]),
      .side_i  (da_side[i]),
      .valid_o (da_v[i+1]),
      .num_o   (da_num[i+1]),
      .rem_o   (da_rem[i+1]),
      .quo_o   (da_quo[i+1]),
      .den_o   (da_den[i+1]),
      .side_o  (da_side[i+1])
    );
    qrs_div_cell #(.NW(NW), .SW(DBSW)) u_cell_b (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (db_v[i]),
      .num_i   (db_num[i]),
      .rem_i   (db_rem[i]),
      .quo_i   (db_quo[i]),
      .den_i   (db_den[i]),
      .side_i  (db_side[i]),
      .valid_o (db_v[i+1]),
      .num_o   (db_num[i+1]),
      .rem_o   (db_rem[i+1]),
      .quo_o   (db_quo[i+1]),
      .den_o   (db_den[i+1]),
      .side_o  (db_side[i+1])
    );
  end

  // round half away from zero, apply sign, clip to 32 bits; msb is the clip flag
  function automatic logic [COEF_W:0] round_sat(input logic [NW-1:0]     q,
                                                input logic [COEF_W-1:0] r,
                                                input logic [COEF_W-1:0] d,
                                                input logic              neg);
    logic [NW:0]       qr;
    logic              up;
    logic              sat;
    logic [COEF_W-1:0] val;
    up  = {r, 1'b0} >= {1'b0, d};
    qr  = {1'b0, q} + (NW+1)'(up);
    sat = 1'b0;
    if (neg) begin
      if (qr > (NW+1)'(33'h0_8000_0000)) begin
        sat = 1'b1;
        val = 32'h8000_0000;
      end else begin
        val = ~qr[COEF_W-1:0] + COEF_W'(1);
      end
    end else begin
      if (qr > (NW+1)'(33'h0_7FFF_FFFF)) begin
        sat = 1'b1;
        val = 32'h7FFF_FFFF;
      end else begin
        val = qr[COEF_W-1:0];
      end
    end
    return {sat, val};
  endfunction

  logic [COEF_W:0]   fa, fb;
  kind_e             f_kind;
  logic [COEF_W-1:0] first_d, second_d;
  logic              sat_d;

  always_comb begin
    f_kind   = kind_e'(da_side[NW][DASW-1:1]);
    fa       = round_sat(da_quo[NW], da_rem[NW], da_den[NW], da_side[NW][0]);
    fb       = round_sat(db_quo[NW], db_rem[NW], db_den[NW], db_side[NW][0]);
    first_d  = '0;
    second_d = '0;
    sat_d    = 1'b0;
    unique case (f_kind)
      KIND_LINEAR, KIND_DOUBLE: begin
        first_d = fa[COEF_W-1:0];
        sat_d   = fa[COEF_W];
      end
      KIND_REAL, KIND_COMPLEX: begin
        first_d  = fa[COEF_W-1:0];
        second_d = fb[COEF_W-1:0];
        sat_d    = fa[COEF_W] | fb[COEF_W];
      end
      default: begin
        sat_d = 1'b0;
      end
    endcase
  end

  // output register
  kind_e             kind_q;
  logic [COEF_W-1:0] first_q, second_q;
  logic              sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= da_v[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q   <= f_kind;
      first_q  <= first_d;
      second_q <= second_d;
      sat_q    <= sat_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign first_value_o  = first_q;
  assign second_value_o = second_q;
  assign saturated_o    = sat_q;

endmodule
